// ----- hw/rtl/cgla_pkg.sv -----
// Shared types and constants for the commit graph lane assigner.
`timescale 1ns / 1ps

package cgla_pkg;

    // Default sizing
    localparam int LANES_DEF       = 32;
    localparam int MAX_PARENTS_DEF = 4;
    localparam int ID_BITS_DEF     = 16;

    // Fixed port widths
    localparam int PARENT_FIELDS = 4;
    localparam int ID_W          = 16;
    localparam int CNT_W         = 3;
    localparam int PIDX_W        = 2;
    localparam int LANE_OUT_W    = 6;

    // Commands from the sequencer to the lane table
    typedef struct packed {
        logic clear;      // free every slot
        logic write;      // mark slot idx busy, waiting for wr_id
        logic drop_dups;  // free every match except the first one
        logic retire;     // free slot idx
    } cgla_cmd_t;

    // Result of the shared compare unit
    typedef struct packed {
        logic hit;     // some busy slot waits for the key
        logic vacant;  // some slot is free
    } cgla_stat_t;

endpackage

// ----- hw/rtl/cgla_lane_table.sv -----
// Lane table storage with the shared key compare and priority encoders.
`timescale 1ns / 1ps

module cgla_lane_table #(
    parameter int  LANES     = cgla_pkg::LANES_DEF,
    parameter int  ID_BITS   = cgla_pkg::ID_BITS_DEF,
    localparam int LANE_BITS = (LANES > 1) ? $clog2(LANES) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cgla_pkg::cgla_cmd_t  cmd,
    input  logic [LANE_BITS-1:0] idx,
    input  logic [ID_BITS-1:0]   wr_id,
    input  logic [ID_BITS-1:0]   key,
    output cgla_pkg::cgla_stat_t stat,
    output logic [LANE_BITS-1:0] hit_idx,
    output logic [LANE_BITS-1:0] free_idx
);
    import cgla_pkg::*;

    logic [LANES-1:0] busy_reg;
    logic [LANES-1:0] busy_next;
    logic [ID_BITS-1:0] waits_reg [LANES];
    logic [LANES-1:0] match;

    // Parallel compare of the key against every busy slot
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            match[i] = busy_reg[i] && (waits_reg[i] == key);
        end
    end

    // First matching slot and first free slot
    always_comb
    begin
        stat     = '0;
        hit_idx  = '0;
        free_idx = '0;
        for (int i = LANES - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                stat.hit = 1'b1;
                hit_idx  = LANE_BITS'(i);
            end
            if (!busy_reg[i])
            begin
                stat.vacant = 1'b1;
                free_idx    = LANE_BITS'(i);
            end
        end
    end

    // Busy bit updates
    always_comb
    begin
        busy_next = busy_reg;
        if (cmd.clear)
        begin
            busy_next = '0;
        end
        else
        begin
            if (cmd.drop_dups)
            begin
                for (int i = 0; i < LANES; i++)
                begin
                    if (match[i] && (LANE_BITS'(i) != hit_idx))
                    begin
                        busy_next[i] = 1'b0;
                    end
                end
            end
            if (cmd.write)
            begin
                busy_next[idx] = 1'b1;
            end
            if (cmd.retire)
            begin
                busy_next[idx] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    // Waited-for ids, only read behind a busy bit
    always_ff @(posedge clk)
    begin
        if (cmd.write)
        begin
            waits_reg[idx] <= wr_id;
        end
    end

endmodule

// ----- hw/rtl/commit_graph_lane_assigner.sv -----
// Top level: commit lane assignment sequencer around the shared lane table compare.
//
//  channel | direction | fields                                          | handshake
//  --------+-----------+-------------------------------------------------+--------------------
//  in      | input     | start_of_graph commit_id parent_count parent_a-d | in_valid / in_stall
//  out     | output    | assigned_lane lanes_in_use overflow             | out_valid / out_stall
//
// A request passes through accept, one commit lookup, one step per parent (or one release
// step for a root commit), and the load of the output register; the parent count is capped
// at min(MAX_PARENTS, 4). Every step uses the one lane table compare unit. in_stall is high
// from accept until the result moves to the output register. A result waits there under
// out_stall while the next request is taken; that request holds in its load cycle until
// the register is free. Reset clears all busy bits and the high mark at once.
`timescale 1ns / 1ps

module commit_graph_lane_assigner #(
    parameter int LANES       = cgla_pkg::LANES_DEF,
    parameter int MAX_PARENTS = cgla_pkg::MAX_PARENTS_DEF,
    parameter int ID_BITS     = cgla_pkg::ID_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            start_of_graph,
    input  logic [cgla_pkg::ID_W-1:0]       commit_id,
    input  logic [cgla_pkg::CNT_W-1:0]      parent_count,
    input  logic [cgla_pkg::ID_W-1:0]       parent_a,
    input  logic [cgla_pkg::ID_W-1:0]       parent_b,
    input  logic [cgla_pkg::ID_W-1:0]       parent_c,
    input  logic [cgla_pkg::ID_W-1:0]       parent_d,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [cgla_pkg::LANE_OUT_W-1:0] assigned_lane,
    output logic [cgla_pkg::LANE_OUT_W-1:0] lanes_in_use,
    output logic                            overflow
);
    import cgla_pkg::*;

    localparam int LANE_BITS = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int MARK_BITS = $clog2(LANES + 1);
    localparam int CNT_LIM   = (MAX_PARENTS < PARENT_FIELDS) ? MAX_PARENTS : PARENT_FIELDS;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_LOOKUP = 2'd1;
    localparam logic [1:0] ST_PARENT = 2'd2;
    localparam logic [1:0] ST_DONE   = 2'd3;

    logic [1:0]           state_reg,   state_next;
    logic [ID_BITS-1:0]   commit_reg,  commit_next;
    logic [ID_BITS-1:0]   par_reg [PARENT_FIELDS];
    logic [ID_BITS-1:0]   par_next [PARENT_FIELDS];
    logic [CNT_W-1:0]     cnt_reg,     cnt_next;
    logic [PIDX_W-1:0]    k_reg,       k_next;
    logic [LANE_BITS-1:0] lane_reg,    lane_next;
    logic                 lane_ok_reg, lane_ok_next;
    logic                 ovf_reg,     ovf_next;
    logic [MARK_BITS-1:0] mark_reg,    mark_next;
    logic                 out_valid_reg, out_valid_next;
    logic [LANE_OUT_W-1:0] out_lane_reg, out_lane_next;
    logic [LANE_OUT_W-1:0] out_mark_reg, out_mark_next;
    logic                 out_ovf_reg,   out_ovf_next;

    cgla_cmd_t            cmd;
    cgla_stat_t           stat;
    logic [LANE_BITS-1:0] tbl_idx;
    logic [ID_BITS-1:0]   key;
    logic [LANE_BITS-1:0] hit_idx;
    logic [LANE_BITS-1:0] free_idx;
    logic [MARK_BITS-1:0] bump_mark;
    logic                 last_step;

    cgla_lane_table #(
        .LANES   (LANES),
        .ID_BITS (ID_BITS)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .idx      (tbl_idx),
        .wr_id    (key),
        .key      (key),
        .stat     (stat),
        .hit_idx  (hit_idx),
        .free_idx (free_idx)
    );

    // Key into the shared compare: the commit, then each parent in turn
    assign key = (state_reg == ST_LOOKUP) ? commit_reg : par_reg[k_reg];

    // High mark after allocating the first free slot
    always_comb
    begin
        bump_mark = mark_reg;
        if (MARK_BITS'(free_idx) + MARK_BITS'(1) > mark_reg)
        begin
            bump_mark = MARK_BITS'(free_idx) + MARK_BITS'(1);
        end
    end

    assign last_step = (cnt_reg == '0) || ({1'b0, k_reg} + CNT_W'(1) == cnt_reg);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        commit_next    = commit_reg;
        par_next       = par_reg;
        cnt_next       = cnt_reg;
        k_next         = k_reg;
        lane_next      = lane_reg;
        lane_ok_next   = lane_ok_reg;
        ovf_next       = ovf_reg;
        mark_next      = mark_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_lane_next  = out_lane_reg;
        out_mark_next  = out_mark_reg;
        out_ovf_next   = out_ovf_reg;
        cmd            = '0;
        tbl_idx        = lane_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.clear   = start_of_graph;
                    commit_next = ID_BITS'(commit_id);
                    par_next[0] = ID_BITS'(parent_a);
                    par_next[1] = ID_BITS'(parent_b);
                    par_next[2] = ID_BITS'(parent_c);
                    par_next[3] = ID_BITS'(parent_d);
                    cnt_next    = (parent_count > CNT_W'(CNT_LIM)) ? CNT_W'(CNT_LIM)
                                                                   : parent_count;
                    k_next      = '0;
                    ovf_next    = 1'b0;
                    if (start_of_graph)
                    begin
                        mark_next = '0;
                    end
                    state_next  = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                // Commit lane: first waiting lane, else first free lane
                if (stat.hit)
                begin
                    cmd.drop_dups = 1'b1;
                    lane_next     = hit_idx;
                    lane_ok_next  = 1'b1;
                end
                else if (stat.vacant)
                begin
                    cmd.write    = 1'b1;
                    tbl_idx      = free_idx;
                    lane_next    = free_idx;
                    lane_ok_next = 1'b1;
                    mark_next    = bump_mark;
                end
                else
                begin
                    lane_ok_next = 1'b0;
                    ovf_next     = 1'b1;
                end
                state_next = ST_PARENT;
            end
            ST_PARENT:
            begin
                if (cnt_reg == '0)
                begin
                    // Root commit ends its lane
                    cmd.retire = lane_ok_reg;
                end
                else if (k_reg == '0)
                begin
                    // First parent continues the commit's lane
                    cmd.write = lane_ok_reg;
                end
                else if (!stat.hit)
                begin
                    // Merge parent with no waiting lane
                    if (stat.vacant)
                    begin
                        cmd.write = 1'b1;
                        tbl_idx   = free_idx;
                        mark_next = bump_mark;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                if (last_step)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    k_next = k_reg + PIDX_W'(1);
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_lane_next  = lane_ok_reg ? LANE_OUT_W'(lane_reg)
                                                 : LANE_OUT_W'(LANES);
                    out_mark_next  = LANE_OUT_W'(mark_reg);
                    out_ovf_next   = ovf_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mark_reg      <= '0;
            out_valid_reg <= 1'b0;
            lane_ok_reg   <= 1'b0;
            ovf_reg       <= 1'b0;
            cnt_reg       <= '0;
            k_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            mark_reg      <= mark_next;
            out_valid_reg <= out_valid_next;
            lane_ok_reg   <= lane_ok_next;
            ovf_reg       <= ovf_next;
            cnt_reg       <= cnt_next;
            k_reg         <= k_next;
        end
    end

    // Request and result payload
    always_ff @(posedge clk)
    begin
        commit_reg   <= commit_next;
        par_reg      <= par_next;
        lane_reg     <= lane_next;
        out_lane_reg <= out_lane_next;
        out_mark_reg <= out_mark_next;
        out_ovf_reg  <= out_ovf_next;
    end

    assign in_stall      = (state_reg != ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign assigned_lane = out_lane_reg;
    assign lanes_in_use  = out_mark_reg;
    assign overflow      = out_ovf_reg;

    // Checks
    a_accept_to_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_LOOKUP))
        else $error("accepted request did not start the commit lookup");

    a_mark_bound: assert property (@(posedge clk) disable iff (!rst_n)
        mark_reg <= MARK_BITS'(LANES))
        else $error("lane high mark above lane count");

    a_ovf_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ovf_reg) |-> $past(!stat.hit && !stat.vacant))
        else $error("overflow set without a full table");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result loaded outside the done step");

endmodule
